// ===== rtl/f2d_pkg.sv =====
// Shared constants and types for the single-precision to decimal text block.
// No dependencies; used by f2d_align, f2d_unit, float_to_decimal_text and the testbench.
package f2d_pkg;

  // Word widths of the conversion datapath
  localparam int unsigned BinW      = 64;             // integer part
  localparam int unsigned FracW     = 59;             // fraction, weight 2^-59 per lsb
  localparam int unsigned AlignW    = BinW + FracW;   // fixed-point value after alignment
  localparam int unsigned MantW     = 24;             // mantissa with hidden one
  localparam int unsigned ShW       = 7;              // alignment shift, 0..99
  localparam int unsigned IntDigits = 20;             // decimal digits of a 64-bit value
  localparam int unsigned BcdW      = 4 * IntDigits;
  localparam int unsigned NdW       = 5;              // holds 0..IntDigits
  localparam int unsigned StepW     = 6;              // double-dabble step count, 0..63

  // Exponent field limits: below ExpTiny prints 0, from ExpHuge on saturates
  localparam logic [7:0] ExpTiny = 8'd91;    // unbiased -36
  localparam logic [7:0] ExpHuge = 8'd191;   // unbiased 64

  // Character codes, six bits of ASCII
  localparam logic [5:0] ChMinus = 6'd45;
  localparam logic [5:0] ChPoint = 6'd46;
  localparam logic [5:0] ChZero  = 6'd48;

  // Operations of the shared step unit
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_LOAD       = 3'd1,
    OP_DABBLE     = 3'd2,
    OP_TIMES10    = 3'd3,
    OP_SHIFT_INT  = 3'd4,
    OP_SHIFT_FRAC = 3'd5
  } op_e;

  // Sequencer to step unit
  typedef struct packed {
    op_e  op;
  } unit_ctrl_t;

  // Step unit to sequencer
  typedef struct packed {
    logic       sign;
    logic [3:0] int_top;      // most significant BCD digit
    logic [3:0] frac_top;     // next fraction digit to print
    logic       new_digit_nz; // digit produced by this cycle's times-ten is non-zero
  } unit_stat_t;

endpackage

// ===== rtl/f2d_align.sv =====
// Unpacks a single-precision word and aligns its mantissa to 64.59 fixed point.
// Depends on f2d_pkg.
module f2d_align (
  input  logic [31:0]                float_bits_i,
  output logic                       sign_o,
  output logic [f2d_pkg::BinW-1:0]   ipart_o,
  output logic [f2d_pkg::FracW-1:0]  frac_o
);

  logic [7:0]                   exp_field;
  logic [7:0]                   exp_off;
  logic [f2d_pkg::MantW-1:0]    mant;
  logic [f2d_pkg::AlignW-1:0]   aligned;

  assign sign_o    = float_bits_i[31];
  assign exp_field = float_bits_i[30:23];
  assign mant      = {1'b1, float_bits_i[22:0]};
  assign exp_off   = exp_field - f2d_pkg::ExpTiny;

  // mant * 2^(e-23) placed so that bit 59 has weight one
  assign aligned = {{(f2d_pkg::AlignW - f2d_pkg::MantW){1'b0}}, mant}
                   << exp_off[f2d_pkg::ShW-1:0];

  // Range selection: tiny prints zero, huge saturates
  always_comb begin
    if (exp_field < f2d_pkg::ExpTiny) begin
      ipart_o = '0;
      frac_o  = '0;
    end else if (exp_field >= f2d_pkg::ExpHuge) begin
      ipart_o = '1;
      frac_o  = '0;
    end else begin
      ipart_o = aligned[f2d_pkg::AlignW-1:f2d_pkg::FracW];
      frac_o  = aligned[f2d_pkg::FracW-1:0];
    end
  end

endmodule

// ===== rtl/f2d_unit.sv =====
// Shared step unit: binary-to-BCD shift-add-3, fraction times ten, digit shifts.
// Depends on f2d_pkg and f2d_align.
module f2d_unit #(
  parameter int unsigned FracDigits = 4
) (
  input  logic                    clk_i,
  input  logic [31:0]             float_bits_i,
  input  f2d_pkg::unit_ctrl_t     ctrl_i,
  output f2d_pkg::unit_stat_t     stat_o
);

  localparam int unsigned ProdW = f2d_pkg::FracW + 4;

  logic                          sign_q, sign_d;
  logic [f2d_pkg::BinW-1:0]      bin_q, bin_d;
  logic [f2d_pkg::BcdW-1:0]      bcd_q, bcd_d;
  logic [f2d_pkg::FracW-1:0]     frac_q, frac_d;
  logic [3:0]                    fd_q [FracDigits];
  logic [3:0]                    fd_d [FracDigits];

  logic                          al_sign;
  logic [f2d_pkg::BinW-1:0]      al_ipart;
  logic [f2d_pkg::FracW-1:0]     al_frac;
  logic [f2d_pkg::BcdW-1:0]      bcd_adj;
  logic [ProdW-1:0]              prod;
  logic [3:0]                    new_digit;
  logic [3:0]                    fd_in;

  f2d_align u_align (
    .float_bits_i (float_bits_i),
    .sign_o       (al_sign),
    .ipart_o      (al_ipart),
    .frac_o       (al_frac)
  );

  // Add 3 to every BCD digit of five or more ahead of the shift
  always_comb begin
    for (int i = 0; i < f2d_pkg::IntDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  // Fraction times ten as 8x + 2x; the top nibble is the next digit
  assign prod      = ({4'b0000, frac_q} << 3) + ({4'b0000, frac_q} << 1);
  assign new_digit = prod[ProdW-1 -: 4];

  // Next-state selection per operation
  always_comb begin
    sign_d = sign_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    frac_d = frac_q;
    fd_in  = 4'd0;
    for (int i = 0; i < FracDigits; i++) begin
      fd_d[i] = fd_q[i];
    end
    case (ctrl_i.op)
      f2d_pkg::OP_LOAD: begin
        sign_d = al_sign;
        bin_d  = al_ipart;
        bcd_d  = '0;
        frac_d = al_frac;
      end
      f2d_pkg::OP_DABBLE: begin
        bcd_d = {bcd_adj[f2d_pkg::BcdW-2:0], bin_q[f2d_pkg::BinW-1]};
        bin_d = {bin_q[f2d_pkg::BinW-2:0], 1'b0};
      end
      f2d_pkg::OP_TIMES10: begin
        frac_d = prod[f2d_pkg::FracW-1:0];
        fd_in  = new_digit;
        fd_d[0] = fd_in;
        for (int i = 1; i < FracDigits; i++) begin
          fd_d[i] = fd_q[i-1];
        end
      end
      f2d_pkg::OP_SHIFT_INT: begin
        bcd_d = {bcd_q[f2d_pkg::BcdW-5:0], 4'd0};
      end
      f2d_pkg::OP_SHIFT_FRAC: begin
        fd_d[0] = fd_in;
        for (int i = 1; i < FracDigits; i++) begin
          fd_d[i] = fd_q[i-1];
        end
      end
      default: begin
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    frac_q <= frac_d;
    for (int i = 0; i < FracDigits; i++) begin
      fd_q[i] <= fd_d[i];
    end
  end

  assign stat_o.sign         = sign_q;
  assign stat_o.int_top      = bcd_q[f2d_pkg::BcdW-1 -: 4];
  assign stat_o.frac_top     = fd_q[FracDigits-1];
  assign stat_o.new_digit_nz = (new_digit != 4'd0);

endmodule

// ===== rtl/float_to_decimal_text.sv =====
// Single-precision to decimal text: one ASCII character per output word, the
// final character of each number flagged on last_o. An input word is taken
// only when the block is idle. It then runs a 64-step binary-to-BCD loop on
// the integer part, FRACTION_DIGITS times-ten steps on the fraction and one
// shift per dropped leading zero, then sends one character per cycle while
// the output side is ready. Most of the time spent on each number goes to
// the binary-to-BCD loop.
// Depends on f2d_pkg and f2d_unit.
module float_to_decimal_text #(
  parameter int unsigned FRACTION_DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] float_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  char_code_o,
  output logic        last_o
);

  localparam int unsigned FcW = $clog2(FRACTION_DIGITS + 1);
  localparam logic [FcW-1:0] FracLast = FcW'(FRACTION_DIGITS - 1);
  localparam logic [f2d_pkg::StepW-1:0] DabbleLast = '1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DABBLE = 8'b0000_0010,
    S_FRAC   = 8'b0000_0100,
    S_SKIP   = 8'b0000_1000,
    S_SIGN   = 8'b0001_0000,
    S_INT    = 8'b0010_0000,
    S_POINT  = 8'b0100_0000,
    S_FDIG   = 8'b1000_0000
  } state_e;

  state_e                      state_q, state_d;
  logic [f2d_pkg::StepW-1:0]   cnt_q, cnt_d;
  logic [f2d_pkg::NdW-1:0]     nd_q, nd_d;
  logic [FcW-1:0]              fcnt_q, fcnt_d;
  logic [FcW-1:0]              nf_q, nf_d;
  logic [FcW-1:0]              fcnt_inc;
  logic                        out_valid_q, out_valid_d;
  logic [5:0]                  char_q, char_d;
  logic                        last_q, last_d;
  logic                        slot_free;
  logic                        emit;
  f2d_pkg::unit_ctrl_t         ctrl;
  f2d_pkg::unit_stat_t         stat;

  f2d_unit #(
    .FracDigits (FRACTION_DIGITS)
  ) u_unit (
    .clk_i        (clk_i),
    .float_bits_i (float_bits_i),
    .ctrl_i       (ctrl),
    .stat_o       (stat)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign fcnt_inc   = fcnt_q + 1'b1;

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    nd_d    = nd_q;
    fcnt_d  = fcnt_q;
    nf_d    = nf_q;
    ctrl.op = f2d_pkg::OP_HOLD;
    emit    = 1'b0;
    char_d  = char_q;
    last_d  = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl.op = f2d_pkg::OP_LOAD;
          cnt_d   = '0;
          state_d = S_DABBLE;
        end
      end
      S_DABBLE: begin
        ctrl.op = f2d_pkg::OP_DABBLE;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == DabbleLast) begin
          fcnt_d  = '0;
          nf_d    = '0;
          state_d = S_FRAC;
        end
      end
      S_FRAC: begin
        ctrl.op = f2d_pkg::OP_TIMES10;
        fcnt_d  = fcnt_inc;
        if (stat.new_digit_nz) begin
          nf_d = fcnt_inc;
        end
        if (fcnt_q == FracLast) begin
          nd_d    = f2d_pkg::NdW'(f2d_pkg::IntDigits);
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (nd_q > f2d_pkg::NdW'(1) && stat.int_top == 4'd0) begin
          ctrl.op = f2d_pkg::OP_SHIFT_INT;
          nd_d    = nd_q - 1'b1;
        end else begin
          state_d = stat.sign ? S_SIGN : S_INT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          emit    = 1'b1;
          char_d  = f2d_pkg::ChMinus;
          last_d  = 1'b0;
          state_d = S_INT;
        end
      end
      S_INT: begin
        if (slot_free) begin
          emit    = 1'b1;
          char_d  = f2d_pkg::ChZero | {2'b00, stat.int_top};
          last_d  = (nd_q == f2d_pkg::NdW'(1)) && (nf_q == '0);
          ctrl.op = f2d_pkg::OP_SHIFT_INT;
          nd_d    = nd_q - 1'b1;
          if (nd_q == f2d_pkg::NdW'(1)) begin
            state_d = (nf_q != '0) ? S_POINT : S_IDLE;
          end
        end
      end
      S_POINT: begin
        if (slot_free) begin
          emit    = 1'b1;
          char_d  = f2d_pkg::ChPoint;
          last_d  = 1'b0;
          fcnt_d  = '0;
          state_d = S_FDIG;
        end
      end
      S_FDIG: begin
        if (slot_free) begin
          emit    = 1'b1;
          char_d  = f2d_pkg::ChZero | {2'b00, stat.frac_top};
          last_d  = (fcnt_inc == nf_q);
          ctrl.op = f2d_pkg::OP_SHIFT_FRAC;
          fcnt_d  = fcnt_inc;
          if (fcnt_inc == nf_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      nd_q        <= '0;
      fcnt_q      <= '0;
      nf_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      nd_q        <= nd_d;
      fcnt_q      <= fcnt_d;
      nf_q        <= nf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DABBLE && cnt_q == '0))
    else $error("accepted word did not start the BCD loop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DABBLE && cnt_q == DabbleLast) |=> (state_q == S_FRAC))
    else $error("BCD loop did not end after 64 steps");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INT || state_q == S_SKIP) |-> (nd_q != '0))
    else $error("integer digit count ran out");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FDIG) |-> (nf_q != '0 && fcnt_q < nf_q))
    else $error("fraction digit index out of range");

endmodule

// ===== dv/float_to_decimal_text_test.sv =====
// Self-checking testbench for float_to_decimal_text: drives float words,
// predicts each number's decimal text and checks every character word.
// Depends on f2d_pkg and float_to_decimal_text.
`timescale 1ns / 100ps

module float_to_decimal_text_test;

  localparam int unsigned FracDigits = 4;
  localparam int unsigned NumRandom  = 85;
  localparam int unsigned SettleCyc  = 150;

  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } char_word_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [31:0] float_bits   = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [5:0]  char_code;
  logic        last;

  logic [31:0] float_backlog [$];
  char_word_t  text_due      [$];
  logic        float_taken   = 1'b0;
  int unsigned floats_in     = 0;
  int unsigned mismatches    = 0;

  // sender burst state
  int unsigned burst_left    = 4;
  int unsigned gap_left      = 0;
  // receiver stall state
  int unsigned rx_phase      = 0;
  int unsigned hold_left     = 0;
  int unsigned holds_done    = 0;

  float_to_decimal_text #(
    .FRACTION_DIGITS(FracDigits)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .float_bits_i(float_bits),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .char_code_o (char_code),
    .last_o      (last)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d, want %0d (float word %0d)", what, got, want,
             floats_in);
    mismatches++;
  endtask

  // Decimal text of one float word, queued as expected character words
  task automatic predict_text(input logic [31:0] bits);
    logic [5:0]  text   [0:39];
    logic [5:0]  digits [0:23];
    int          len;
    int          nd;
    int          point;
    int          e2;
    int unsigned fsh;
    logic [63:0] mant;
    logic [63:0] ipart;
    logic [63:0] fpart;
    logic [63:0] fmask;
    char_word_t  w;
    len   = 0;
    ipart = '0;
    fpart = '0;
    fmask = '0;
    fsh   = 0;
    e2    = int'(bits[30:23]) - 127;
    mant  = {40'd0, 1'b1, bits[22:0]};
    if (bits[31]) begin
      text[len] = f2d_pkg::ChMinus;
      len = len + 1;
    end
    if (e2 < -36) begin
      text[len] = f2d_pkg::ChZero;
      len = len + 1;
    end else begin
      if (e2 >= 64) begin
        ipart = '1;
      end else if (e2 >= 23) begin
        ipart = mant << (e2 - 23);
      end else begin
        fsh   = 23 - e2;
        fmask = (64'd1 << fsh) - 64'd1;
        if (e2 >= 0) ipart = mant >> fsh;
        fpart = mant & fmask;
      end
      // integer part, least significant digit first
      nd = 0;
      do begin
        digits[nd] = f2d_pkg::ChZero + 6'(ipart % 64'd10);
        ipart = ipart / 64'd10;
        nd = nd + 1;
      end while (ipart != 0);
      while (nd > 0) begin
        nd = nd - 1;
        text[len] = digits[nd];
        len = len + 1;
      end
      // truncated fraction digits, trailing zeros and a bare point dropped
      if (fpart != 0) begin
        point = len;
        text[len] = f2d_pkg::ChPoint;
        len = len + 1;
        for (int i = 0; i < FracDigits; i++) begin
          fpart = fpart * 64'd10;
          text[len] = f2d_pkg::ChZero + 6'(fpart >> fsh);
          fpart = fpart & fmask;
          len = len + 1;
        end
        while (len > point + 1 && text[len-1] == f2d_pkg::ChZero) len = len - 1;
        if (len == point + 1) len = len - 1;
      end
    end
    for (int i = 0; i < len; i++) begin
      w.code = text[i];
      w.last = (i == len - 1);
      text_due.push_back(w);
    end
  endtask

  // Random float: mostly printable exponents, some raw words, some edge exponents
  function automatic logic [31:0] random_float();
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [31:0] word;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    frac = 23'($urandom);
    if ($urandom_range(0, 3) == 0) frac = frac & ~((23'd1 << $urandom_range(0, 22)) - 23'd1);
    if (pick <= 5) begin
      if ($urandom_range(0, 1) == 0) expo = 8'($urandom_range(110, 150));
      else expo = 8'($urandom_range(91, 190));
      word = {1'($urandom), expo, frac};
    end else if (pick <= 7) begin
      word = $urandom;
    end else begin
      case ($urandom_range(0, 9))
        0: expo = 8'd0;
        1: expo = 8'd90;
        2: expo = 8'd91;
        3: expo = 8'd126;
        4: expo = 8'd127;
        5: expo = 8'd149;
        6: expo = 8'd150;
        7: expo = 8'd190;
        8: expo = 8'd191;
        default: expo = 8'd255;
      endcase
      word = {1'($urandom), expo, frac};
    end
    return word;
  endfunction

  // Monitor: log accepted floats, check accepted characters
  always @(posedge clk_i) begin
    char_word_t want;
    float_taken <= in_valid && in_ready;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        predict_text(float_bits);
        floats_in <= floats_in + 1;
      end
      if (out_valid && out_ready) begin
        if (text_due.size() == 0) begin
          report_mismatch("unexpected char", 32'(char_code), 0);
        end else begin
          want = text_due.pop_front();
          if (char_code !== want.code) begin
            report_mismatch("char_code", 32'(char_code), 32'(want.code));
          end
          if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
        end
      end
    end
  end

  // Driver: bursts of float words with random gaps
  always @(negedge clk_i) begin
    logic        nxt_valid;
    logic [31:0] nxt_bits;
    nxt_valid = in_valid;
    nxt_bits  = float_bits;
    if (rst_ni) begin
      if (in_valid && float_taken) begin
        nxt_valid = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(20, 120);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (float_backlog.size() > 0) begin
          nxt_bits  = float_backlog.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid   <= nxt_valid;
    float_bits <= nxt_bits;
  end

  // Receiver: changing stall pattern, with two long hold-offs
  always @(negedge clk_i) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (rst_ni) begin
      rx_phase++;
      if (hold_left == 0 &&
          ((holds_done == 0 && floats_in >= 30) || (holds_done == 1 && floats_in >= 80))) begin
        hold_left = 400;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else begin
        case (rx_phase[8:7])
          2'd0: nxt_ready = 1'b1;
          2'd1: nxt_ready = 1'($urandom);
          2'd2: nxt_ready = (rx_phase[1:0] == 2'd0);
          default: nxt_ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end else begin
      nxt_ready = 1'b0;
    end
    out_ready <= nxt_ready;
  end

  // Stimulus and end of run
  initial begin
    // zeros, denormals, tiny limit
    float_backlog.push_back(32'h0000_0000);
    float_backlog.push_back(32'h8000_0000);
    float_backlog.push_back(32'h0000_0001);
    float_backlog.push_back(32'h807F_FFFF);
    float_backlog.push_back(32'h2D7F_FFFF);
    float_backlog.push_back(32'h2D80_0000);
    float_backlog.push_back(32'hAD80_0001);
    // fractions, including ones that truncate away
    float_backlog.push_back(32'h3F80_0000);
    float_backlog.push_back(32'hBFC0_0000);
    float_backlog.push_back(32'h3F00_0000);
    float_backlog.push_back(32'h38D1_B717);
    float_backlog.push_back(32'h4049_0FDB);
    float_backlog.push_back(32'h42F6_E979);
    float_backlog.push_back(32'h3DCC_CCCD);
    float_backlog.push_back(32'h3F7F_FFFF);
    float_backlog.push_back(32'h4120_0000);
    // wide integers up to and beyond the huge limit
    float_backlog.push_back(32'h4B00_0000);
    float_backlog.push_back(32'h4B7F_FFFF);
    float_backlog.push_back(32'h5F00_0000);
    float_backlog.push_back(32'hDF7F_FFFF);
    float_backlog.push_back(32'h5F80_0000);
    float_backlog.push_back(32'h7F80_0000);
    float_backlog.push_back(32'hFF80_0000);
    float_backlog.push_back(32'h7FC0_0001);
    float_backlog.push_back(32'hFFFF_FFFF);
    for (int i = 0; i < NumRandom; i++) float_backlog.push_back(random_float());

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (float_backlog.size() != 0 || in_valid) @(posedge clk_i);
    while (text_due.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
